// ===== rtl/core/blad_pkg.sv =====
package blad_pkg;

    typedef logic [7:0] sample_t;
    typedef logic [6:0] avg_t;
    typedef logic [3:0] digit_t;

    localparam avg_t   PCT_MAX    = 7'd100;
    localparam digit_t DIGIT_BASE = 4'd10;
    localparam digit_t DIGIT_TOP  = 4'd9;

    // x / 10 == (x * 205) >> 11 for every x up to 1028
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int unsigned DIV10_SHIFT = 11;

    typedef struct packed {
        sample_t sample_percent;
        logic    charging;
    } in_item_t;

    typedef struct packed {
        avg_t   average_percent;
        digit_t bar_index;
        logic   hundreds_on;
        logic   tens_on;
        digit_t tens_digit;
        digit_t units_digit;
        logic   charging_on;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_HOLD
    } state_t;

    function automatic digit_t tens_of(avg_t a);
        logic [14:0] prod;
        prod = 15'(a) * 15'(DIV10_MUL);
        return digit_t'(prod >> DIV10_SHIFT);
    endfunction

    function automatic digit_t units_of(avg_t a, digit_t t);
        avg_t tens_scaled;
        tens_scaled = avg_t'(t) * avg_t'(DIGIT_BASE);
        return digit_t'(a - tens_scaled);
    endfunction

endpackage

// ===== rtl/core/blad_in_if.sv =====
interface blad_in_if;
    logic                valid;
    logic                ready;
    blad_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/blad_out_if.sv =====
interface blad_out_if;
    logic                valid;
    logic                ready;
    blad_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/blad_window.sv =====
module blad_window #(
    parameter int unsigned WINDOW = 10,
    parameter int unsigned SUM_W  = 10,
    parameter int unsigned CNT_W  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  blad_pkg::avg_t      sample,
    output logic [SUM_W-1:0]    sum,
    output logic [CNT_W-1:0]    count
);

    localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    blad_pkg::avg_t     mem [WINDOW];
    blad_pkg::avg_t     rd_data_reg;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               full;

    assign full = (count_reg == CNT_W'(WINDOW));

    always_comb
    begin
        ptr_next   = ptr_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            // drop the oldest sample once the window is full
            sum_next = sum_reg - (full ? SUM_W'(rd_data_reg) : '0) + SUM_W'(sample);
            if (!full)
                count_next = count_reg + 1'b1;
            if (ptr_reg == PTR_W'(WINDOW - 1))
                ptr_next = '0;
            else
                ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // read the slot under the write pointer every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptr_reg] <= sample;
        rd_data_reg <= mem[ptr_reg];
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

// ===== rtl/core/blad_div.sv =====
module blad_div #(
    parameter int unsigned SUM_W = 10,
    parameter int unsigned CNT_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic [SUM_W-1:0]    quotient,
    output logic                done
);

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   num_reg, num_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic [CNT_W:0]     trial;
    logic               fits;

    // one quotient bit per cycle, dividend shifted out MSB first
    assign trial = {rem_reg, num_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(SUM_W);
        end
        else if (step_reg != '0)
        begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
            num_next  = {num_reg[SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign quotient = num_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/battery_level_average_display_top.sv =====
// Battery gauge smoother: each item carries one battery percentage sample and a
// charging flag and yields exactly one result item, in order. Samples above 100
// are taken as 100. The block keeps the last WINDOW samples and returns the
// truncated mean of all samples received so far until the window is full, then
// of the newest WINDOW, together with the gauge bar index (mean / 10), the
// decimal display digits with their enables, and the charging flag unchanged.
// After acceptance an item passes the divider start, the serial division and the
// hold state before its result is ready. The serial divider makes one quotient
// bit per cycle over the SUM_W bits of the sum, where SUM_W is the bit width of
// 100 * WINDOW. Items are processed one at a time. A new item is accepted while a
// finished result waits in the output register; a second finished result holds
// until that one is taken. Stored samples need no clearing after reset.
module battery_level_average_display_top #(
    parameter int unsigned WINDOW = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    blad_in_if.sink     samples,
    blad_out_if.source  results
);

    localparam int unsigned SUM_W = $clog2(100 * WINDOW + 1);
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);

    blad_pkg::state_t   state_reg, state_next;
    logic               in_ready;
    logic               div_start;
    logic               out_load;

    blad_pkg::avg_t     sample_sat;
    logic               accept;
    logic               charging_reg;

    logic [SUM_W-1:0]   window_sum;
    logic [CNT_W-1:0]   filled_count;
    logic [SUM_W-1:0]   quotient;
    logic               div_done;

    blad_pkg::avg_t     avg;
    blad_pkg::digit_t   tens;
    blad_pkg::out_item_t result;
    blad_pkg::out_item_t out_reg;
    logic               out_valid_reg, out_valid_next;

    // saturate the raw gauge reading to 100
    assign sample_sat = (samples.payload.sample_percent > blad_pkg::sample_t'(blad_pkg::PCT_MAX))
                      ? blad_pkg::PCT_MAX
                      : samples.payload.sample_percent[6:0];
    assign accept = samples.valid && in_ready;

    // window store: update sum and fill count at the accepting edge
    blad_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .sample (sample_sat),
        .sum    (window_sum),
        .count  (filled_count)
    );

    // mean = sum / count, one bit per cycle
    blad_div #(
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (window_sum),
        .divisor  (filled_count),
        .quotient (quotient),
        .done     (div_done)
    );

    // control: accept, start the divider, wait, then hand off to the output register
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            blad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (samples.valid)
                    state_next = blad_pkg::ST_START;
            end
            blad_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = blad_pkg::ST_DIV;
            end
            blad_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = blad_pkg::ST_HOLD;
            end
            blad_pkg::ST_HOLD:
            begin
                // hold the mean until the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = blad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= blad_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            charging_reg <= samples.payload.charging;
    end

    // format the mean for the display
    assign avg  = (quotient > SUM_W'(blad_pkg::PCT_MAX))
                ? blad_pkg::PCT_MAX
                : quotient[6:0];
    assign tens = blad_pkg::tens_of(avg);

    always_comb
    begin
        result.average_percent = avg;
        result.bar_index       = tens;
        result.hundreds_on     = (avg == blad_pkg::PCT_MAX);
        result.tens_on         = (avg != '0);
        result.tens_digit      = (tens > blad_pkg::DIGIT_TOP) ? '0 : tens;
        result.units_digit     = blad_pkg::units_of(avg, tens);
        result.charging_on     = charging_reg;
    end

    // output register: hold the result item until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign samples.ready   = in_ready;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

endmodule

// ===== rtl/core/blad_checker.sv =====
module blad_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  blad_pkg::out_item_t out_item
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item dropped or changed while stalled");

    // one item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item in progress");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.average_percent <= blad_pkg::PCT_MAX
                   && out_item.tens_digit <= blad_pkg::DIGIT_TOP
                   && out_item.units_digit <= blad_pkg::DIGIT_TOP)
        else $error("average or digit out of range");

    a_hundreds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.hundreds_on |-> out_item.tens_on
                   && out_item.tens_digit == '0 && out_item.units_digit == '0
                   && out_item.bar_index == blad_pkg::DIGIT_BASE)
        else $error("inconsistent display at full charge");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.tens_on == (out_item.average_percent != '0))
        else $error("tens enable disagrees with average");

endmodule

bind battery_level_average_display_top blad_checker u_blad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_item  (results.payload)
);
